/* hw/rtl/gcpse_pkg.sv */
// ----------------------------------------------------------------------------
// gcpse_pkg: shared types and constants of the gray code pair swap enumerator
// command codes, beat structs, controller states and command/status groups
// ----------------------------------------------------------------------------
package gcpse_pkg;

	// default sizing of the storage
	localparam int PAIR_SLOTS_DEF  = 16;
	localparam int LABEL_SLOTS_DEF = 64;
	localparam int VALUE_BITS_DEF  = 16;

	// fixed widths of the beat fields
	localparam int CMD_W   = 3;
	localparam int LABEL_W = 6;
	localparam int DATA_W  = 16;

	// step counter and its trailing zero count
	localparam int STEP_BITS = 17;
	localparam int TZ_W      = $clog2(STEP_BITS + 1);

	typedef enum logic [CMD_W-1:0] {
		CMD_RESTART = 3'd0,
		CMD_ADD     = 3'd1,
		CMD_WRITE   = 3'd2,
		CMD_READ    = 3'd3,
		CMD_ADVANCE = 3'd4
	} cmd_e;

	typedef struct packed {
		logic [CMD_W-1:0]          cmd;
		logic [LABEL_W-1:0]        first_label;
		logic [LABEL_W-1:0]        second_label;
		logic signed [DATA_W-1:0]  label_value;
	} item_t;

	typedef struct packed {
		logic                      advanced;
		logic                      ended;
		logic                      swapped;
		logic [LABEL_W-1:0]        swap_first;
		logic [LABEL_W-1:0]        swap_second;
		logic signed [DATA_W-1:0]  read_value;
		logic                      table_full;
	} result_t;

	typedef struct packed {
		logic [LABEL_W-1:0] first;
		logic [LABEL_W-1:0] second;
	} pair_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_RD_WAIT,
		S_ADV_SEL,
		S_ADV_FETCH,
		S_SWAP_A,
		S_SWAP_B,
		S_RESP
	} state_e;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic clr;
		logic pair_push;
		logic wr_value;
		logic rd_value;
		logic rd_capture;
		logic step_inc;
		logic sel_calc;
		logic pair_fetch;
		logic swap_wr_a;
		logic swap_wr_b;
	} ctl_t;

	// datapath to controller
	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic             ended;
		logic             swap_ok;
	} sts_t;

endpackage

/* hw/rtl/gcpse_ctrl.sv */
// ----------------------------------------------------------------------------
// gcpse_ctrl: command sequencer
// walks each accepted command through its datapath steps and strobes the result
// ----------------------------------------------------------------------------
module gcpse_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  gcpse_pkg::sts_t sts,
	output gcpse_pkg::ctl_t ctl,
	output logic            busy,
	output logic            done
);
	import gcpse_pkg::*;

	state_e state_q;
	state_e state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) state_d = S_EXEC;
			end
			S_EXEC: begin
				case (sts.cmd)
					CMD_READ:    state_d = S_RD_WAIT;
					CMD_ADVANCE: state_d = sts.ended ? S_RESP : S_ADV_SEL;
					default:     state_d = S_RESP;
				endcase
			end
			S_RD_WAIT:   state_d = S_RESP;
			S_ADV_SEL:   state_d = S_ADV_FETCH;
			S_ADV_FETCH: state_d = S_SWAP_A;
			S_SWAP_A:    state_d = sts.swap_ok ? S_SWAP_B : S_RESP;
			S_SWAP_B:    state_d = S_RESP;
			S_RESP:      state_d = S_IDLE;
			default:     state_d = S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		ctl  = '0;
		busy = (state_q != S_IDLE);
		done = 1'b0;
		case (state_q)
			S_IDLE: begin
				ctl.capture = start;
			end
			S_EXEC: begin
				case (sts.cmd)
					CMD_RESTART: ctl.clr       = 1'b1;
					CMD_ADD:     ctl.pair_push = 1'b1;
					CMD_WRITE:   ctl.wr_value  = 1'b1;
					CMD_READ:    ctl.rd_value  = 1'b1;
					CMD_ADVANCE: ctl.step_inc  = !sts.ended;
					default:     ctl = '0;
				endcase
			end
			S_RD_WAIT:   ctl.rd_capture = 1'b1;
			S_ADV_SEL:   ctl.sel_calc   = 1'b1;
			S_ADV_FETCH: ctl.pair_fetch = 1'b1;
			S_SWAP_A:    ctl.swap_wr_a  = sts.swap_ok;
			S_SWAP_B:    ctl.swap_wr_b  = 1'b1;
			S_RESP:      done           = 1'b1;
			default:     ctl = '0;
		endcase
	end

endmodule

/* hw/rtl/gcpse_dp.sv */
// ----------------------------------------------------------------------------
// gcpse_dp: enumerator datapath
// pair table, label value memory, step counter and result register
// ----------------------------------------------------------------------------
module gcpse_dp #(
	parameter int PAIR_SLOTS  = gcpse_pkg::PAIR_SLOTS_DEF,
	parameter int LABEL_SLOTS = gcpse_pkg::LABEL_SLOTS_DEF,
	parameter int VALUE_BITS  = gcpse_pkg::VALUE_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  gcpse_pkg::item_t   item,
	input  gcpse_pkg::ctl_t    ctl,
	output gcpse_pkg::sts_t    sts,
	output gcpse_pkg::result_t result
);
	import gcpse_pkg::*;

	localparam int PC_W = $clog2(PAIR_SLOTS + 1);
	localparam int PI_W = (PAIR_SLOTS > 1) ? $clog2(PAIR_SLOTS) : 1;
	localparam int LA_W = $clog2(LABEL_SLOTS);

	function automatic logic lbl_ok(input logic [LABEL_W-1:0] l);
		lbl_ok = (32'(l) < LABEL_SLOTS);
	endfunction

	item_t                        cmd_q;
	result_t                      res_q;
	logic [PC_W-1:0]              pc_q;
	logic [STEP_BITS-1:0]         step_q;
	logic                         done_q;
	pair_t                        pair_tab [PAIR_SLOTS];
	logic [PI_W-1:0]              sel_q;
	logic                         swap_req_q;
	logic [LABEL_W-1:0]           a_q;
	logic [LABEL_W-1:0]           b_q;
	logic                         ok_q;
	logic signed [VALUE_BITS-1:0] mem [LABEL_SLOTS];
	logic signed [VALUE_BITS-1:0] rd_a_q;
	logic signed [VALUE_BITS-1:0] rd_b_q;

	logic                         full;
	logic [TZ_W-1:0]              tz;
	logic                         tz_ge;
	pair_t                        pair_rd;
	logic [LABEL_W-1:0]           rd_a_lbl;
	logic                         mem_we;
	logic [LABEL_W-1:0]           mem_wlbl;
	logic signed [VALUE_BITS-1:0] mem_wdata;
	logic signed [31:0]           wr_ext;
	logic signed [31:0]           rd_ext;

	assign full    = (pc_q == PC_W'(PAIR_SLOTS));
	assign pair_rd = pair_tab[sel_q];
	assign wr_ext  = 32'(cmd_q.label_value);
	assign rd_ext  = 32'(rd_a_q);

	// trailing zeros of the step count, counter width when it wrapped to zero
	always_comb begin
		tz = TZ_W'(STEP_BITS);
		for (int i = STEP_BITS - 1; i >= 0; i--) begin
			if (step_q[i]) tz = TZ_W'(i);
		end
	end
	assign tz_ge = (32'(tz) >= 32'(pc_q));

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q   <= '0;
			step_q <= '0;
			done_q <= 1'b0;
		end else begin
			if (ctl.clr) begin
				pc_q   <= '0;
				step_q <= '0;
				done_q <= 1'b0;
			end
			if (ctl.pair_push && !full) pc_q <= pc_q + 1'b1;
			if (ctl.step_inc) step_q <= step_q + 1'b1;
			if (ctl.sel_calc && tz_ge) done_q <= 1'b1;
		end
	end

	// pair table
	always_ff @(posedge clk) begin
		if (ctl.pair_push && !full) begin
			pair_tab[PI_W'(pc_q)] <= '{first: cmd_q.first_label, second: cmd_q.second_label};
		end
	end

	// command capture, pair selection and result
	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			cmd_q <= item;
			res_q <= '0;
		end
		if (ctl.pair_push && full) res_q.table_full <= 1'b1;
		if (ctl.rd_capture) begin
			res_q.read_value <= lbl_ok(cmd_q.first_label) ? rd_ext[DATA_W-1:0] : '0;
		end
		if (ctl.sel_calc) begin
			res_q.advanced <= 1'b1;
			// past the last pair the last swap is undone
			sel_q      <= tz_ge ? PI_W'(pc_q - 1'b1) : PI_W'(tz);
			swap_req_q <= !tz_ge || (pc_q != '0);
		end
		if (ctl.pair_fetch) begin
			a_q  <= pair_rd.first;
			b_q  <= pair_rd.second;
			ok_q <= swap_req_q && lbl_ok(pair_rd.first) && lbl_ok(pair_rd.second);
		end
		if (ctl.swap_wr_a) begin
			res_q.swapped     <= 1'b1;
			res_q.swap_first  <= a_q;
			res_q.swap_second <= b_q;
		end
	end

	// label value memory, two registered read ports and one write port
	assign rd_a_lbl = ctl.pair_fetch ? pair_rd.first : cmd_q.first_label;

	always_comb begin
		mem_we    = 1'b0;
		mem_wlbl  = cmd_q.first_label;
		mem_wdata = wr_ext[VALUE_BITS-1:0];
		if (ctl.wr_value) begin
			mem_we = lbl_ok(cmd_q.first_label);
		end else if (ctl.swap_wr_a) begin
			mem_we    = 1'b1;
			mem_wlbl  = a_q;
			mem_wdata = rd_b_q;
		end else if (ctl.swap_wr_b) begin
			mem_we    = 1'b1;
			mem_wlbl  = b_q;
			mem_wdata = rd_a_q;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[LA_W'(mem_wlbl)] <= mem_wdata;
		if (ctl.rd_value || ctl.pair_fetch) rd_a_q <= mem[LA_W'(rd_a_lbl)];
		if (ctl.pair_fetch) rd_b_q <= mem[LA_W'(pair_rd.second)];
	end

	always_comb begin
		result       = res_q;
		result.ended = done_q;
	end

	assign sts.cmd     = cmd_q.cmd;
	assign sts.ended   = done_q;
	assign sts.swap_ok = ok_q;

endmodule

/* hw/rtl/gray_code_pair_swap_enumerator.sv */
// ----------------------------------------------------------------------------
// gray_code_pair_swap_enumerator: gray code walk over pair swaps
// holds label values and label pairs and steps through every combination of
// pair swaps so that each advance exchanges the values of at most one pair
// ----------------------------------------------------------------------------
// a command beat is taken when start is high and busy is low; its single
// result beat appears on result for exactly one cycle with done high, and the
// receiver cannot hold it off, so result must be sampled on that cycle. one
// command is in flight at a time, so no new command is taken until the last
// one is through: restart, add pair, value write and unknown codes pass from
// accept through exec and resp, a value read adds a registered memory read
// (rd_wait), an advance after the end goes from exec to resp, and an advance
// that steps goes through select, fetch and swap_a, then swap_b when it swaps,
// since both writes of the swap share the single write port of the value memory.
// ended always shows the current end flag; a swap naming a label outside the
// value table still counts as a step but reports swapped low.
// ----------------------------------------------------------------------------
module gray_code_pair_swap_enumerator #(
	parameter int PAIR_SLOTS  = gcpse_pkg::PAIR_SLOTS_DEF,
	parameter int LABEL_SLOTS = gcpse_pkg::LABEL_SLOTS_DEF,
	parameter int VALUE_BITS  = gcpse_pkg::VALUE_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  gcpse_pkg::item_t   item,
	output logic               done,
	output gcpse_pkg::result_t result
);
	import gcpse_pkg::*;

	// command and status between sequencer and datapath
	ctl_t ctl;
	sts_t sts;

	gcpse_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.ctl    (ctl),
		.busy   (busy),
		.done   (done)
	);

	// value memory, pair table, step counter and the result register
	gcpse_dp #(
		.PAIR_SLOTS  (PAIR_SLOTS),
		.LABEL_SLOTS (LABEL_SLOTS),
		.VALUE_BITS  (VALUE_BITS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.ctl    (ctl),
		.sts    (sts),
		.result (result)
	);

endmodule
